// ===== hw/rtl/brce_pkg.sv =====
// brce_pkg: types and constants of the bar code raster encoder
// segment kinds, register indexes, reset values and the segment sequencer phases
// no dependencies
package brce_pkg;

    // segment kinds
    localparam logic [1:0] KIND_SOLID = 2'd0;
    localparam logic [1:0] KIND_ALT   = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_BYTES_PER_LINE = 2'd0;
    localparam logic [1:0] REG_LINES_PER_PAGE = 2'd1;
    localparam logic [1:0] REG_TIMING_INTERVAL = 2'd2;
    localparam logic [1:0] REG_EXTRA_LINES    = 2'd3;

    // register reset values
    localparam logic [6:0]  BPL_RESET = 7'd32;
    localparam logic [12:0] LPP_RESET = 13'd1024;
    localparam logic [11:0] TI_RESET  = 12'd341;

    // page framing
    localparam int LPP_MIN          = 14;
    localparam int FRAME_ROWS       = 4;
    localparam int FRAME_ROWS_EXTRA = 10;
    localparam int WIDTH_EXTRA      = 5;
    localparam int FILL_EXTRA       = 3;

    typedef enum logic [4:0] {
        PH_START,
        PH_OPEN_TIMING,
        PH_OPEN_WHITE,
        PH_BLK_WHITE1,
        PH_BLK_TIMING,
        PH_BLK_WHITE2,
        PH_MARK,
        PH_LEFT_WHITE,
        PH_DATA,
        PH_PAD,
        PH_END_WHITE,
        PH_END_MARK,
        PH_FILL_MARK1,
        PH_FILL_RUN,
        PH_FILL_MARK2,
        PH_CLOSE_WHITE,
        PH_CLOSE_TIMING
    } brce_phase_t;

endpackage

// ===== hw/rtl/bar_code_raster_encoder.sv =====
// bar_code_raster_encoder: run segments of paged bar code rasters from payload bytes, uses brce_pkg
// a request is held in the request registers; its first segment is loaded into the output register
// once it is empty or not stalled; throughput: one segment per cycle from the segment sequencer
// into the single output register unless stalled; a request gives one segment for most bytes,
// up to sixteen at a row and page boundary; the next is taken in the cycle its last segment is loaded
// reset: asynchronous, clears counters, page state and output valid, loads register defaults
module bar_code_raster_encoder
    import brce_pkg::*;
#(
    parameter int MAX_BYTES_PER_LINE = 64,
    parameter int MAX_LINES_PER_PAGE = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  seg_kind,
    output logic        seg_value,
    output logic [9:0]  seg_length,
    output logic [7:0]  seg_byte,
    output logic        page_end,
    output logic [12:0] page_height,
    output logic        last
);

    localparam int EB_W = $clog2(MAX_BYTES_PER_LINE + 1);
    localparam int CW   = (EB_W > 7) ? EB_W : 7;
    localparam int WW   = CW + 4;
    localparam int LB_W = $clog2(MAX_LINES_PER_PAGE + 1);
    localparam int LW   = (LB_W > 13) ? LB_W : 13;

    // configuration registers
    logic [6:0]  bpl_reg, bpl_next;
    logic [12:0] lpp_reg, lpp_next;
    logic [11:0] ti_reg, ti_next;
    logic        extra_reg, extra_next;

    // encoder state
    logic [6:0]  bir_reg, bir_next;
    logic [11:0] rop_reg, rop_next;
    logic [11:0] rst_reg, rst_next;
    logic        mark_reg, mark_next;
    logic        open_reg, open_next;
    logic [12:0] prc_reg, prc_next;

    // held request
    logic        busy_reg, busy_next;
    logic [7:0]  item_data_reg, item_data_next;
    logic        item_fin_reg, item_fin_next;
    brce_phase_t phase_reg, phase_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic        value_reg, value_next;
    logic [9:0]  length_reg, length_next;
    logic [7:0]  byte_reg, byte_next;
    logic        pe_reg, pe_next;
    logic [12:0] ph_reg, ph_next;
    logic        last_reg, last_next;

    logic          cfg_write;
    logic [CW-1:0] eff_bpl;
    logic [WW-1:0] page_w;
    logic [WW-1:0] fill_w;
    logic [WW-1:0] pad_w;
    logic [LW-1:0] lpp_clamp;
    logic [LW-1:0] max_rows;
    logic          blk_due;
    brce_phase_t   cur_phase;
    brce_phase_t   nxt_phase;
    logic          seg_last;
    logic          step_fire;
    logic          accept;

    function automatic logic [12:0] add_rows(input logic [12:0] cnt, input logic [1:0] k);
        logic [13:0] sum;
        sum = {1'b0, cnt} + 14'(k);
        return sum[13] ? 13'h1FFF : sum[12:0];
    endfunction

    function automatic logic [11:0] inc_sat12(input logic [11:0] cnt);
        return (cnt == 12'hFFF) ? cnt : cnt + 12'd1;
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        bpl_next   = bpl_reg;
        lpp_next   = lpp_reg;
        ti_next    = ti_reg;
        extra_next = extra_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_BYTES_PER_LINE:  bpl_next   = pwdata[6:0];
                REG_LINES_PER_PAGE:  lpp_next   = pwdata[12:0];
                REG_TIMING_INTERVAL: ti_next    = pwdata[11:0];
                REG_EXTRA_LINES:     extra_next = pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BYTES_PER_LINE:  prdata = {25'd0, bpl_reg};
            REG_LINES_PER_PAGE:  prdata = {19'd0, lpp_reg};
            REG_TIMING_INTERVAL: prdata = {20'd0, ti_reg};
            REG_EXTRA_LINES:     prdata = {31'd0, extra_reg};
        endcase
    end

    // effective geometry
    always_comb
    begin
        if (bpl_reg == 7'd0)
            eff_bpl = CW'(1);
        else if (CW'(bpl_reg) > CW'(MAX_BYTES_PER_LINE))
            eff_bpl = CW'(MAX_BYTES_PER_LINE);
        else
            eff_bpl = CW'(bpl_reg);

        if (LW'(lpp_reg) < LW'(LPP_MIN))
            lpp_clamp = LW'(LPP_MIN);
        else if (LW'(lpp_reg) > LW'(MAX_LINES_PER_PAGE))
            lpp_clamp = LW'(MAX_LINES_PER_PAGE);
        else
            lpp_clamp = LW'(lpp_reg);

        max_rows = lpp_clamp - (extra_reg ? LW'(FRAME_ROWS_EXTRA) : LW'(FRAME_ROWS));
    end

    assign page_w  = {1'b0, eff_bpl, 3'b000} + WW'(WIDTH_EXTRA);
    assign fill_w  = {1'b0, eff_bpl, 3'b000} + WW'(FILL_EXTRA);
    assign pad_w   = {1'b0, eff_bpl - CW'(bir_reg), 3'b000};
    assign blk_due = extra_reg && (rst_reg == ti_reg);

    // first phase of a request follows from the page and row state
    always_comb
    begin
        if (phase_reg != PH_START)
            cur_phase = phase_reg;
        else if (!open_reg)
            cur_phase = PH_OPEN_TIMING;
        else if (bir_reg != 7'd0)
            cur_phase = PH_DATA;
        else if (blk_due)
            cur_phase = PH_BLK_WHITE1;
        else
            cur_phase = PH_MARK;
    end

    // segment sequencer: one segment and its state update per step
    always_comb
    begin
        kind_next   = KIND_SOLID;
        value_next  = 1'b0;
        length_next = 10'd0;
        byte_next   = 8'd0;
        pe_next     = 1'b0;
        ph_next     = 13'd0;
        bir_next    = bir_reg;
        rop_next    = rop_reg;
        rst_next    = rst_reg;
        mark_next   = mark_reg;
        open_next   = open_reg;
        prc_next    = prc_reg;
        nxt_phase   = PH_START;

        unique case (cur_phase)
            PH_OPEN_TIMING:
            begin
                kind_next   = KIND_ALT;
                length_next = page_w[9:0];
                bir_next    = 7'd0;
                rop_next    = 12'd0;
                rst_next    = 12'd0;
                mark_next   = 1'b0;
                prc_next    = 13'd0;
                nxt_phase   = PH_OPEN_WHITE;
            end
            PH_OPEN_WHITE:
            begin
                value_next  = 1'b1;
                length_next = page_w[9:0];
                prc_next    = add_rows(prc_reg, 2'd2);
                open_next   = 1'b1;
                nxt_phase   = blk_due ? PH_BLK_WHITE1 : PH_MARK;
            end
            PH_BLK_WHITE1:
            begin
                value_next  = 1'b1;
                length_next = page_w[9:0];
                nxt_phase   = PH_BLK_TIMING;
            end
            PH_BLK_TIMING:
            begin
                kind_next   = KIND_ALT;
                length_next = page_w[9:0];
                nxt_phase   = PH_BLK_WHITE2;
            end
            PH_BLK_WHITE2:
            begin
                value_next  = 1'b1;
                length_next = page_w[9:0];
                prc_next    = add_rows(prc_reg, 2'd3);
                rst_next    = 12'd0;
                mark_next   = 1'b0;
                nxt_phase   = PH_MARK;
            end
            PH_MARK:
            begin
                value_next  = mark_reg;
                length_next = 10'd1;
                nxt_phase   = PH_LEFT_WHITE;
            end
            PH_LEFT_WHITE:
            begin
                value_next  = 1'b1;
                length_next = 10'd1;
                nxt_phase   = PH_DATA;
            end
            PH_DATA:
            begin
                kind_next   = KIND_DATA;
                length_next = 10'd8;
                byte_next   = item_data_reg;
                bir_next    = (bir_reg == 7'h7F) ? bir_reg : bir_reg + 7'd1;
                if (CW'(bir_next) >= eff_bpl)
                    nxt_phase = PH_END_WHITE;
                else if (item_fin_reg)
                    nxt_phase = PH_PAD;
                else
                    nxt_phase = PH_START;
            end
            PH_PAD:
            begin
                value_next  = 1'b1;
                length_next = pad_w[9:0];
                nxt_phase   = PH_END_WHITE;
            end
            PH_END_WHITE:
            begin
                value_next  = 1'b1;
                length_next = 10'd2;
                nxt_phase   = PH_END_MARK;
            end
            PH_END_MARK:
            begin
                value_next  = mark_reg;
                length_next = 10'd1;
                mark_next   = !mark_reg;
                rop_next    = inc_sat12(rop_reg);
                rst_next    = inc_sat12(rst_reg);
                prc_next    = add_rows(prc_reg, 2'd1);
                bir_next    = 7'd0;
                // page full, or payload done with the row closed
                if ((LW'(rop_next) >= max_rows) || item_fin_reg)
                    nxt_phase = prc_next[0] ? PH_CLOSE_WHITE : PH_FILL_MARK1;
                else
                    nxt_phase = PH_START;
            end
            PH_FILL_MARK1:
            begin
                value_next  = mark_reg;
                length_next = 10'd1;
                nxt_phase   = PH_FILL_RUN;
            end
            PH_FILL_RUN:
            begin
                value_next  = 1'b1;
                length_next = fill_w[9:0];
                nxt_phase   = PH_FILL_MARK2;
            end
            PH_FILL_MARK2:
            begin
                value_next  = mark_reg;
                length_next = 10'd1;
                prc_next    = add_rows(prc_reg, 2'd1);
                nxt_phase   = PH_CLOSE_WHITE;
            end
            PH_CLOSE_WHITE:
            begin
                value_next  = 1'b1;
                length_next = page_w[9:0];
                prc_next    = add_rows(prc_reg, 2'd2);
                nxt_phase   = PH_CLOSE_TIMING;
            end
            PH_CLOSE_TIMING:
            begin
                kind_next   = KIND_ALT;
                length_next = page_w[9:0];
                pe_next     = 1'b1;
                ph_next     = prc_reg;
                open_next   = 1'b0;
                bir_next    = 7'd0;
                rop_next    = 12'd0;
                rst_next    = 12'd0;
                mark_next   = 1'b0;
                prc_next    = 13'd0;
                nxt_phase   = PH_START;
            end
            default:
            begin
                nxt_phase = PH_START;
            end
        endcase

        seg_last  = (nxt_phase == PH_START);
        last_next = seg_last;
    end

    // handshake
    assign step_fire = busy_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = busy_reg && !(step_fire && seg_last);
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        busy_next      = busy_reg;
        item_data_next = item_data_reg;
        item_fin_next  = item_fin_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;

        if (step_fire)
        begin
            phase_next     = seg_last ? PH_START : nxt_phase;
            out_valid_next = 1'b1;
            if (seg_last)
                busy_next = 1'b0;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            busy_next      = 1'b1;
            item_data_next = data_byte;
            item_fin_next  = final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpl_reg       <= BPL_RESET;
            lpp_reg       <= LPP_RESET;
            ti_reg        <= TI_RESET;
            extra_reg     <= 1'b0;
            bir_reg       <= 7'd0;
            rop_reg       <= 12'd0;
            rst_reg       <= 12'd0;
            mark_reg      <= 1'b0;
            open_reg      <= 1'b0;
            prc_reg       <= 13'd0;
            busy_reg      <= 1'b0;
            phase_reg     <= PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bpl_reg       <= bpl_next;
            lpp_reg       <= lpp_next;
            ti_reg        <= ti_next;
            extra_reg     <= extra_next;
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (step_fire)
            begin
                bir_reg  <= bir_next;
                rop_reg  <= rop_next;
                rst_reg  <= rst_next;
                mark_reg <= mark_next;
                open_reg <= open_next;
                prc_reg  <= prc_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_data_reg <= item_data_next;
        item_fin_reg  <= item_fin_next;
        if (step_fire)
        begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            length_reg <= length_next;
            byte_reg   <= byte_next;
            pe_reg     <= pe_next;
            ph_reg     <= ph_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign seg_kind    = kind_reg;
    assign seg_value   = value_reg;
    assign seg_length  = length_reg;
    assign seg_byte    = byte_reg;
    assign page_end    = pe_reg;
    assign page_height = ph_reg;
    assign last        = last_reg;

`ifndef SYNTH
    // a closing timing line always ends its request
    a_page_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && page_end |-> last && (seg_kind == KIND_ALT))
        else $error("page end segment not last or not a timing line");

    // the filler row keeps every page height odd
    a_height_odd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && page_end |-> page_height[0])
        else $error("page height even");

    // a new request only enters once the held one has sent its last segment
    a_accept_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && busy_reg |=> out_valid && last)
        else $error("request taken before previous one finished");

    // data segments are always eight pixels
    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (seg_kind == KIND_DATA) |-> (seg_length == 10'd8) && !page_end)
        else $error("bad data segment");
`endif

endmodule
